FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, muted while reset is applied.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen on a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/aes_enc_pkg.sv
`timescale 1ns / 1ps
package aes_enc_pkg;

  typedef logic [3:0][7:0]  word_t;   // byte 0 at index 0
  typedef logic [15:0][7:0] state_t;  // byte n = row n%4, column n/4

  // Block travelling down the cell chain.
  typedef struct packed {
    state_t          st;     // state after the last AddRoundKey
    word_t [7:0]     win;    // last eight key schedule words, oldest at 0
    logic  [2:0]     phase;  // index of next schedule word modulo Nk
    logic  [7:0]     rc;     // next round constant
  } cell_data_t;

  localparam int unsigned NumCells = 14;

  localparam logic [1:0] KeySize128 = 2'd0;
  localparam logic [1:0] KeySize192 = 2'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sub_byte(logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [3:0] nk_of(logic [1:0] ks);
    logic [3:0] n;
    case (ks)
      KeySize128: n = 4'd4;
      KeySize192: n = 4'd6;
      default:    n = 4'd8;
    endcase
    return n;
  endfunction

  // SubBytes followed by ShiftRows
  function automatic state_t sub_shift(state_t s);
    state_t     o;
    logic [1:0] cc;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        cc = 2'(c + r);
        o[r + 4*c] = sub_byte(s[r + 4*int'(cc)]);
      end
    end
    return o;
  endfunction

  function automatic state_t mix(state_t s);
    state_t     o;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c];
      a1 = s[4*c+1];
      a2 = s[4*c+2];
      a3 = s[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      o[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
      o[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
      o[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
      o[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return o;
  endfunction

endpackage

FILE: src/aes_enc_cell.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes_enc_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [3:0]              round_i,     // fixed round number of this cell
  input  logic [1:0]              key_size_i,
  input  aes_enc_pkg::word_t [3:0] key_hi_i,   // key words 4..7
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  aes_enc_pkg::cell_data_t in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output aes_enc_pkg::cell_data_t out_data_o
);

  logic                    vld_q;
  aes_enc_pkg::cell_data_t data_q, data_d;
  aes_enc_pkg::word_t [3:0] nw;
  aes_enc_pkg::word_t      prev, far, temp;
  aes_enc_pkg::state_t     rk, t;
  logic [2:0]              phase;
  logic [7:0]              rc;
  logic [3:0]              nk, nr;

  assign in_ready_o = !vld_q || out_ready_i;

  always_comb begin
    nk    = aes_enc_pkg::nk_of(key_size_i);
    nr    = nk + 4'd6;
    phase = in_data_i.phase;
    rc    = in_data_i.rc;
    prev  = in_data_i.win[7];
    nw    = '0;
    // four schedule words, each from the one before and the one Nk back
    for (int k = 0; k < 4; k++) begin
      case (key_size_i)
        aes_enc_pkg::KeySize128: far = in_data_i.win[4+k];
        aes_enc_pkg::KeySize192: far = in_data_i.win[2+k];
        default:                 far = in_data_i.win[k];
      endcase
      temp = prev;
      if (phase == 3'd0) begin
        temp[0] = aes_enc_pkg::sub_byte(prev[1]) ^ rc;
        temp[1] = aes_enc_pkg::sub_byte(prev[2]);
        temp[2] = aes_enc_pkg::sub_byte(prev[3]);
        temp[3] = aes_enc_pkg::sub_byte(prev[0]);
        rc      = aes_enc_pkg::xtime(rc);
      end else if (nk == 4'd8 && phase == 3'd4) begin
        for (int b = 0; b < 4; b++) temp[b] = aes_enc_pkg::sub_byte(prev[b]);
      end
      // words still inside the key itself come straight from it
      if (round_i == 4'd1 && (4'(k) + 4'd4) < nk) nw[k] = key_hi_i[k];
      else nw[k] = far ^ temp;
      phase = ({1'b0, phase} == nk - 4'd1) ? 3'd0 : phase + 3'd1;
      prev  = nw[k];
    end
    for (int k = 0; k < 4; k++)
      for (int b = 0; b < 4; b++) rk[4*k+b] = nw[k][b];

    t = in_data_i.st;
    if (round_i <= nr) begin
      t = aes_enc_pkg::sub_shift(t);
      if (round_i != nr) t = aes_enc_pkg::mix(t);
      t = t ^ rk;
    end

    data_d.st    = t;
    data_d.phase = phase;
    data_d.rc    = rc;
    for (int i = 0; i < 4; i++) begin
      data_d.win[i]   = in_data_i.win[i+4];
      data_d.win[i+4] = nw[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

  `ASSERT_CLK(a_cell_hold, vld_q && !out_ready_i |=> vld_q && $stable(data_q), "cell lost a block")
endmodule

FILE: src/aes_block_encrypt.sv
`timescale 1ns / 1ps
// Pipeline: an accepted request reaches m_axis as ciphertext through one input stage
//   and fourteen round cells; shorter keys pass through the spare cells unchanged.
// Throughput: one block per cycle, set by the chain of round cells; each cell stalls only
//   when it is full and the cell after it cannot take its block.
// Reset: asynchronous, active low; empties the chain and clears key size and key to zero.
`include "assert_macros.svh"
module aes_block_encrypt (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // plain_high [63:0], plain_low [127:64]
  // result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // cipher_high [63:0], cipher_low [127:64]
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  // register map, 8 bytes apart
  localparam logic [2:0] RegKeySize = 3'd0;
  localparam logic [2:0] RegKey0    = 3'd1;
  localparam logic [2:0] RegKey1    = 3'd2;
  localparam logic [2:0] RegKey2    = 3'd3;
  localparam logic [2:0] RegKey3    = 3'd4;

  localparam int unsigned N = aes_enc_pkg::NumCells;

  logic [1:0]       key_size_q;
  logic [3:0][63:0] key_q;
  logic             wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= '0;
      key_q      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegKeySize: key_size_q <= pwdata[1:0];
        RegKey0:    key_q[0]   <= pwdata;
        RegKey1:    key_q[1]   <= pwdata;
        RegKey2:    key_q[2]   <= pwdata;
        RegKey3:    key_q[3]   <= pwdata;
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegKeySize: prdata = {62'd0, key_size_q};
      RegKey0:    prdata = key_q[0];
      RegKey1:    prdata = key_q[1];
      RegKey2:    prdata = key_q[2];
      RegKey3:    prdata = key_q[3];
      default:    prdata = '0;
    endcase
  end

  // key words 0..7; byte 0 of a word sits in the top bits of its half
  aes_enc_pkg::word_t [7:0] key_w;
  always_comb begin
    for (int j = 0; j < 8; j++)
      for (int b = 0; b < 4; b++)
        key_w[j][b] = key_q[j/2][63 - 32*(j%2) - 8*b -: 8];
  end

  // input stage: initial AddRoundKey, seed the schedule window
  aes_enc_pkg::state_t     pt;
  aes_enc_pkg::cell_data_t in_d, in_q;
  logic                    in_vld_q, in_rdy;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pt[k]   = s_axis_tdata[63 - 8*k -: 8];
      pt[k+8] = s_axis_tdata[127 - 8*k -: 8];
    end
    for (int k = 0; k < 16; k++) in_d.st[k] = pt[k] ^ key_w[k/4][k%4];
    for (int i = 0; i < 4; i++) begin
      in_d.win[i]   = '0;
      in_d.win[i+4] = key_w[i];
    end
    in_d.phase = (key_size_q == aes_enc_pkg::KeySize128) ? 3'd0 : 3'd4;
    in_d.rc    = 8'h01;
  end

  logic                    c_vld [N+1];
  logic                    c_rdy [N+1];
  aes_enc_pkg::cell_data_t c_dat [N+1];

  assign s_axis_tready = !in_vld_q || c_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
  end

  assign c_vld[0] = in_vld_q;
  assign c_dat[0] = in_q;
  assign in_rdy   = c_rdy[0];

  // one cell per round
  for (genvar g = 0; g < N; g++) begin : g_cell
    aes_enc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .round_i    (4'(g + 1)),
      .key_size_i (key_size_q),
      .key_hi_i   (key_w[7:4]),
      .in_valid_i (c_vld[g]),
      .in_ready_o (c_rdy[g]),
      .in_data_i  (c_dat[g]),
      .out_valid_o(c_vld[g+1]),
      .out_ready_i(c_rdy[g+1]),
      .out_data_o (c_dat[g+1])
    );
  end

  assign c_rdy[N]      = m_axis_tready;
  assign m_axis_tvalid = c_vld[N];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      m_axis_tdata[63 - 8*k -: 8]  = c_dat[N].st[k];
      m_axis_tdata[127 - 8*k -: 8] = c_dat[N].st[k+8];
    end
  end

  `ASSERT_CLK(a_in_lands, s_axis_tvalid && s_axis_tready |=> in_vld_q, "request not captured")
  `ASSERT_CLK(a_in_hold, in_vld_q && !in_rdy |=> in_vld_q && $stable(in_q), "input stage lost a block")
  `ASSERT_NEVER(a_out_hold_rdy, m_axis_tvalid && !c_rdy[N-1] && m_axis_tready, "last cell stalled while sink ready")
endmodule
